// ----- rtl/rar_pkg.sv -----
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types for the rational ALU: opcodes, sequencer states and the
// classification flags passed from the front end to the back end.
// ----------------------------------------------------------------------------
package rar_pkg;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_GCD,
    B_SCALE,
    B_DIVN,
    B_DIVD,
    B_DIVW,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic zero_den;
    logic zero_num;
    logic neg;
  } job_flags_t;

  localparam int unsigned FLAGS_W = $bits(job_flags_t);

endpackage

// ----- rtl/rar_front.sv -----
// ----------------------------------------------------------------------------
// rar_front
// Accepts an item, forms the cross products with one shared multiplier,
// combines them into numerator and denominator magnitudes and classifies.
// ----------------------------------------------------------------------------
module rar_front #(
  parameter int unsigned W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            cmd,
  input  logic signed [W-1:0]   a_num,
  input  logic signed [W-1:0]   a_den,
  input  logic signed [W-1:0]   b_num,
  input  logic signed [W-1:0]   b_den,
  output logic                  push,
  input  logic                  q_full,
  output rar_pkg::job_flags_t   push_flags,
  output logic [2*W-1:0]        push_n,
  output logic [2*W-1:0]        push_d
);

  localparam int unsigned M = 2 * W;

  rar_pkg::front_state_t state, state_next;
  rar_pkg::cmd_t         op;
  logic [1:0]            step;
  logic                  s_an, s_ad, s_bn, s_bd;
  logic [W-1:0]          m_an, m_ad, m_bn, m_bd;
  logic [M-1:0]          prod [4];
  logic [W-1:0]          mx, my;
  logic                  xs, ys, ns, ds;
  logic [M-1:0]          xm, ym, nm, dm;

  // Select multiplier operands: an*bd, ad*bn, ad*bd, an*bn
  always_comb begin
    case (step)
      2'd0:    begin mx = m_an; my = m_bd; end
      2'd1:    begin mx = m_ad; my = m_bn; end
      2'd2:    begin mx = m_ad; my = m_bd; end
      default: begin mx = m_an; my = m_bn; end
    endcase
  end

  // Combine products into signed numerator and denominator
  always_comb begin
    xs = s_an ^ s_bd;
    xm = prod[0];
    ys = s_ad ^ s_bn;
    ym = prod[1];
    ds = s_ad ^ s_bd;
    dm = prod[2];
    ns = xs;
    nm = xm;
    unique case (op) inside
      rar_pkg::CMD_ADD, rar_pkg::CMD_SUB: begin
        if (op == rar_pkg::CMD_SUB) begin
          ys = ~ys;
        end
        if (xs == ys) begin
          nm = xm + ym;
          ns = xs;
        end else if (xm >= ym) begin
          nm = xm - ym;
          ns = xs;
        end else begin
          nm = ym - xm;
          ns = ys;
        end
      end
      rar_pkg::CMD_MUL: begin
        ns = s_an ^ s_bn;
        nm = prod[3];
      end
      default: begin
        ds = ys;
        dm = ym;
      end
    endcase
  end

  // Front state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    in_stall   = (state != rar_pkg::F_IDLE);
    unique case (state)
      rar_pkg::F_IDLE: if (in_valid) state_next = rar_pkg::F_MUL;
      rar_pkg::F_MUL:  if (step == 2'd3) state_next = rar_pkg::F_PUSH;
      rar_pkg::F_PUSH: begin
        if (!q_full) begin
          push       = 1'b1;
          state_next = rar_pkg::F_IDLE;
        end
      end
      default: state_next = rar_pkg::F_IDLE;
    endcase
  end

  // Capture operands in sign-magnitude form, then run the products
  always_ff @(posedge clk) begin
    if (state == rar_pkg::F_IDLE && in_valid) begin
      op   <= rar_pkg::cmd_t'(cmd);
      s_an <= a_num[W-1];
      s_ad <= a_den[W-1];
      s_bn <= b_num[W-1];
      s_bd <= b_den[W-1];
      m_an <= a_num[W-1] ? W'(-a_num) : W'(a_num);
      m_ad <= a_den[W-1] ? W'(-a_den) : W'(a_den);
      m_bn <= b_num[W-1] ? W'(-b_num) : W'(b_num);
      m_bd <= b_den[W-1] ? W'(-b_den) : W'(b_den);
      step <= 2'd0;
    end else if (state == rar_pkg::F_MUL) begin
      prod[step] <= M'(mx * my);
      step       <= step + 2'd1;
    end
  end

  assign push_n              = nm;
  assign push_d              = dm;
  assign push_flags.zero_den = (dm == '0);
  assign push_flags.zero_num = (nm == '0);
  assign push_flags.neg      = ns ^ ds;

endmodule

// ----- rtl/rar_queue.sv -----
// ----------------------------------------------------------------------------
// rar_queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rar_queue #(
  parameter int unsigned DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output logic [DW-1:0] q_data
);

  logic [DW-1:0] mem [2];
  logic          wptr, rptr;
  logic [1:0]    count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = mem[rptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Write storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

endmodule

// ----- rtl/rar_back.sv -----
// ----------------------------------------------------------------------------
// rar_back
// Reduces N/D by a binary GCD, divides with a shared restoring divider and
// splits off the whole part; holds the result until it is taken.
// ----------------------------------------------------------------------------
module rar_back #(
  parameter int unsigned W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  rar_pkg::job_flags_t       q_flags,
  input  logic [2*W-1:0]            q_n,
  input  logic [2*W-1:0]            q_d,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [32:0]        whole_part,
  output logic signed [31:0]        rem_num,
  output logic [30:0]               rem_den,
  output logic                      zero_den_error
);

  localparam int unsigned M  = 2 * W;
  localparam int unsigned CW = $clog2(M);
  localparam int unsigned XW = (M + 1 > 34) ? M + 1 : 34;

  rar_pkg::back_state_t state, state_next;
  logic [M-1:0]  nmag, dmag, u, v;
  logic [CW-1:0] k;
  logic          neg;
  logic [M-1:0]  dq, dr, dv;
  logic [CW-1:0] dcnt;
  logic [M:0]    dt, dsub;
  logic          dge;
  logic [M-1:0]  quot_next, rem_next;
  logic [XW-1:0] qx, rx, dx;

  // One restoring divide step
  always_comb begin
    dt        = {dr, dq[M-1]};
    dsub      = dt - {1'b0, dv};
    dge       = !dsub[M];
    rem_next  = dge ? dsub[M-1:0] : dt[M-1:0];
    quot_next = {dq[M-2:0], dge};
    qx        = {{(XW-M){1'b0}}, quot_next};
    rx        = {{(XW-M){1'b0}}, rem_next};
    dx        = {{(XW-M){1'b0}}, dmag};
    if (neg) begin
      qx = -qx;
      rx = -rx;
    end
  end

  // Back state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_valid  = (state == rar_pkg::B_DONE);
    unique case (state)
      rar_pkg::B_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          if (q_flags.zero_den || q_flags.zero_num) begin
            state_next = rar_pkg::B_DONE;
          end else begin
            state_next = rar_pkg::B_GCD;
          end
        end
      end
      rar_pkg::B_GCD:   if (u == v) state_next = rar_pkg::B_SCALE;
      rar_pkg::B_SCALE: if (k == '0) state_next = rar_pkg::B_DIVN;
      rar_pkg::B_DIVN:  if (dcnt == '0) state_next = rar_pkg::B_DIVD;
      rar_pkg::B_DIVD:  if (dcnt == '0) state_next = rar_pkg::B_DIVW;
      rar_pkg::B_DIVW:  if (dcnt == '0) state_next = rar_pkg::B_DONE;
      rar_pkg::B_DONE:  if (!out_stall) state_next = rar_pkg::B_IDLE;
      default:          state_next = rar_pkg::B_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      rar_pkg::B_IDLE: begin
        nmag <= q_n;
        dmag <= q_d;
        u    <= q_n;
        v    <= q_d;
        k    <= '0;
        neg  <= q_flags.neg;
        whole_part     <= '0;
        rem_num        <= '0;
        rem_den        <= q_flags.zero_den ? 31'd0 : 31'd1;
        zero_den_error <= q_flags.zero_den;
      end
      rar_pkg::B_GCD: begin
        if (u != v) begin
          if (!u[0] && !v[0]) begin
            u <= u >> 1;
            v <= v >> 1;
            k <= k + CW'(1);
          end else if (!u[0]) begin
            u <= u >> 1;
          end else if (!v[0]) begin
            v <= v >> 1;
          end else if (u > v) begin
            u <= u - v;
          end else begin
            v <= v - u;
          end
        end
      end
      rar_pkg::B_SCALE: begin
        // restore the shared power of two, then start N / g
        if (k != '0) begin
          u <= u << 1;
          k <= k - CW'(1);
        end else begin
          dq   <= nmag;
          dr   <= '0;
          dv   <= u;
          dcnt <= CW'(M - 1);
        end
      end
      rar_pkg::B_DIVN: begin
        dq   <= quot_next;
        dr   <= rem_next;
        dcnt <= dcnt - CW'(1);
        if (dcnt == '0) begin
          nmag <= quot_next;
          dq   <= dmag;
          dr   <= '0;
          dcnt <= CW'(M - 1);
        end
      end
      rar_pkg::B_DIVD: begin
        dq   <= quot_next;
        dr   <= rem_next;
        dcnt <= dcnt - CW'(1);
        if (dcnt == '0) begin
          dmag <= quot_next;
          dv   <= quot_next;
          dq   <= nmag;
          dr   <= '0;
          dcnt <= CW'(M - 1);
        end
      end
      rar_pkg::B_DIVW: begin
        dq   <= quot_next;
        dr   <= rem_next;
        dcnt <= dcnt - CW'(1);
        if (dcnt == '0) begin
          whole_part     <= qx[32:0];
          rem_num        <= rx[31:0];
          rem_den        <= dx[30:0];
          zero_den_error <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == rar_pkg::B_GCD |-> u != '0 && v != '0)
    else $error("gcd operand reached zero");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_den_error |-> whole_part == '0 && rem_num == '0 && rem_den == '0)
    else $error("error result not cleared");
  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !zero_den_error && W <= 16 |-> rem_den != '0)
    else $error("zero denominator without error");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    state == rar_pkg::B_SCALE && state_next == rar_pkg::B_DIVN |=> dv != '0)
    else $error("divide by zero started");
`endif

endmodule

// ----- rtl/rational_alu_reduce_mixed_unit.sv -----
// ----------------------------------------------------------------------------
// rational_alu_reduce_mixed_unit
// Rational ALU: a/b op c/d, reduced to lowest terms, split into whole part
// and signed remainder fraction.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  cmd, a_num, a_den, b_num, b_den
//  out      out_valid/out_stall  whole_part, rem_num, rem_den, zero_den_error
//
//  Front end: capture, four products on one multiplier, combine; it takes a new
//  item only when idle. A two-entry queue decouples it from the back end.
//  Back end: binary GCD, restore of the shared power of two, then three divides
//  on the shared divider; it takes the next item from the queue only when idle.
//  A zero numerator or denominator skips the GCD and the divides.
//  Reset empties the queue and returns both sequencers to idle.
// ----------------------------------------------------------------------------
module rational_alu_reduce_mixed_unit #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     cmd,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [32:0]             whole_part,
  output logic signed [31:0]             rem_num,
  output logic [30:0]                    rem_den,
  output logic                           zero_den_error
);

  localparam int unsigned M  = 2 * OPERAND_WIDTH;
  localparam int unsigned DW = rar_pkg::FLAGS_W + 2 * M;

  logic                push, q_full, pop, q_valid;
  rar_pkg::job_flags_t push_flags, q_flags;
  logic [M-1:0]        push_n, push_d, q_n, q_d;
  logic [DW-1:0]       q_data;

  rar_front #(.W(OPERAND_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .cmd, .a_num, .a_den, .b_num, .b_den,
    .push, .q_full, .push_flags, .push_n, .push_d
  );

  rar_queue #(.DW(DW)) u_queue (
    .clk, .rst, .push,
    .push_data ({push_flags, push_n, push_d}),
    .full      (q_full),
    .pop, .q_valid, .q_data
  );

  assign q_flags = q_data[DW-1 -: rar_pkg::FLAGS_W];
  assign q_n     = q_data[2*M-1:M];
  assign q_d     = q_data[M-1:0];

  rar_back #(.W(OPERAND_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_flags, .q_n, .q_d, .pop,
    .out_valid, .out_stall, .whole_part, .rem_num, .rem_den, .zero_den_error
  );

endmodule
